@@ hdl/lru_pkg.sv @@
// Package for the LRU page replacement core: build defaults, register map
// and configuration port constants. No dependencies.
package lru_pkg;

  // Build defaults for the top-level parameters
  localparam int FramesDef   = 8;
  localparam int PageBitsDef = 16;

  // Field widths fixed by the stream formats
  localparam int PageNumW  = 16;
  localparam int FrameIdxW = 3;
  localparam int FaultW    = 32;
  localparam int ActiveW   = 4;

  // Output word: hit, frame_index, evicted_valid, evicted_page, fault_total
  localparam int OutFieldW = 1 + FrameIdxW + 1 + PageNumW + FaultW;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // Configuration port
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  typedef enum logic [0:0] {
    REG_ACTIVE_FRAMES = 1'b0
  } reg_idx_e;

  localparam logic [ActiveW-1:0] ActiveFramesRst = ActiveW'(8);

endpackage

@@ hdl/lru_page_replacement_core.sv @@
// LRU page replacement core: frame tags, valid bits, recency ranks and the
// fault counter, with a stream in, a stream out and an APB register port.
// Depends on lru_pkg.
//
//  channel   | dir | handshake              | word
//  ----------+-----+------------------------+----------------------------------
//  s_axis    | in  | tvalid / tready        | page_number[15:0]
//  m_axis    | out | tvalid / tready        | hit, frame_index, evicted_valid,
//            |     |                        | evicted_page, fault_total
//  apb       | in  | psel / penable / pready| active_frames at byte address 0
//
//  Each accepted word is held in the input register; the lookup, the
//  victim choice and the rank update run combinationally from there and land
//  in the result register and the frame state at the same edge.
//  A word moves from input to result register. One word per cycle is sustained
//  while not stalled, set by the single tag-compare and rank-update pass.
//  A stalled result holds only the stages behind it; the input register
//  keeps taking words while the result register is free or being drained.
//  Reset clears valid bits, ranks, fill count, fault count and both stages;
//  frame tags are not reset, since they are only read behind a valid bit.
module lru_page_replacement_core
  import lru_pkg::*;
#(
  parameter int FRAMES    = FramesDef,
  parameter int PAGE_BITS = PageBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream; tdata: page_number[15:0]
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [PageNumW-1:0] s_axis_tdata,
  // output stream; tdata: hit[0], frame_index[3:1], evicted_valid[4],
  // evicted_page[20:5], fault_total[52:21], zero fill[55:53]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int FIdxW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RankW = FIdxW;
  localparam int CntW  = $clog2(FRAMES + 1);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [ActiveW-1:0] active_q;
  logic               cfg_wr;
  logic               cfg_hit_addr;

  assign pready       = 1'b1;
  assign cfg_hit_addr = (paddr[ApbAddrW-1:2] == REG_ACTIVE_FRAMES);
  assign cfg_wr       = psel && penable && pwrite && pready && cfg_hit_addr;
  assign prdata       = cfg_hit_addr ? ApbDataW'(active_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActiveFramesRst;
    end else if (cfg_wr) begin
      active_q <= pwdata[ActiveW-1:0];
    end
  end

  // Clamp the register into 1..FRAMES
  logic [CntW+ActiveW-1:0] active_ext;
  logic [CntW-1:0]         n_eff;

  assign active_ext = (CntW + ActiveW)'(active_q);

  always_comb begin
    if (active_q == '0) begin
      n_eff = CntW'(1);
    end else if (active_ext > (CntW + ActiveW)'(FRAMES)) begin
      n_eff = CntW'(FRAMES);
    end else begin
      n_eff = active_ext[CntW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Input register and stage control
  // ---------------------------------------------------------------------
  logic                 in_vld_q;
  logic [PageNumW-1:0]  in_page_q;
  logic                 out_vld_q;
  logic                 adv;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_page_q <= s_axis_tdata;
    end
  end

  // Page as stored, cut or widened to PAGE_BITS
  logic [PAGE_BITS+PageNumW-1:0] page_ext;
  logic [PAGE_BITS-1:0]          page;

  assign page_ext = {{PAGE_BITS{1'b0}}, in_page_q};
  assign page     = page_ext[PAGE_BITS-1:0];

  // ---------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------
  logic [PAGE_BITS-1:0] frame_page_q [FRAMES];
  logic [FRAMES-1:0]    frame_valid_q;
  logic [RankW-1:0]     rank_q [FRAMES];
  logic [RankW-1:0]     rank_d [FRAMES];
  logic [CntW-1:0]      filled_q;
  logic [FaultW-1:0]    fault_q;
  logic [FaultW-1:0]    fault_d;

  // ---------------------------------------------------------------------
  // Lookup: tag compare, first match wins
  // ---------------------------------------------------------------------
  logic [FRAMES-1:0] act_mask;
  logic [FRAMES-1:0] match;
  logic              hit;
  logic [FIdxW-1:0]  hit_idx;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      act_mask[i] = (CntW'(i) < n_eff);
      match[i]    = act_mask[i] && frame_valid_q[i] && (frame_page_q[i] == page);
    end
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = FIdxW'(i);
      end
    end
  end

  assign hit = |match;

  // ---------------------------------------------------------------------
  // Victim: oldest active frame, higher index on a tie
  // ---------------------------------------------------------------------
  logic [FRAMES-1:0] wins;
  logic [FIdxW-1:0]  vic_idx;

  always_comb begin
    vic_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      wins[i] = act_mask[i] && frame_valid_q[i];
      for (int j = 0; j < FRAMES; j++) begin
        if (j != i && act_mask[j] && frame_valid_q[j]) begin
          if (!((rank_q[j] < rank_q[i]) || ((rank_q[j] == rank_q[i]) && (j < i)))) begin
            wins[i] = 1'b0;
          end
        end
      end
    end
    for (int i = 0; i < FRAMES; i++) begin
      if (wins[i]) begin
        vic_idx = FIdxW'(i);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Frame choice and recency update
  // ---------------------------------------------------------------------
  logic             do_fill;
  logic             do_evict;
  logic [FIdxW-1:0] sel_idx;
  logic [RankW-1:0] old_rank;
  logic             age_all;

  assign do_fill  = !hit && (filled_q < n_eff);
  assign do_evict = !hit && !do_fill;
  assign sel_idx  = hit ? hit_idx : (do_fill ? filled_q[FIdxW-1:0] : vic_idx);
  assign old_rank = rank_q[sel_idx];
  assign age_all  = do_fill;

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      rank_d[i] = rank_q[i];
      if (FIdxW'(i) == sel_idx) begin
        rank_d[i] = '0;
      end else if (frame_valid_q[i] && (age_all || (rank_q[i] < old_rank))) begin
        rank_d[i] = rank_q[i] + RankW'(1);
      end
    end
  end

  // Saturating fault count
  always_comb begin
    fault_d = fault_q;
    if (!hit && (fault_q != {FaultW{1'b1}})) begin
      fault_d = fault_q + FaultW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= '0;
      filled_q      <= '0;
      fault_q       <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (adv) begin
      fault_q <= fault_d;
      rank_q  <= rank_d;
      if (do_fill) begin
        frame_valid_q[sel_idx] <= 1'b1;
        filled_q               <= filled_q + CntW'(1);
      end
    end
  end

  // Tags carry no reset
  always_ff @(posedge clk_i) begin
    if (adv && !hit) begin
      frame_page_q[sel_idx] <= page;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic [PageNumW+PAGE_BITS-1:0] ev_ext;
  logic [FIdxW+FrameIdxW-1:0]    fidx_ext;

  logic                  res_hit_q;
  logic [FrameIdxW-1:0]  res_fidx_q;
  logic                  res_ev_vld_q;
  logic [PageNumW-1:0]   res_ev_page_q;
  logic [FaultW-1:0]     res_fault_q;

  assign ev_ext   = {{PageNumW{1'b0}}, frame_page_q[sel_idx]};
  assign fidx_ext = {{FrameIdxW{1'b0}}, sel_idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_hit_q     <= hit;
      res_fidx_q    <= fidx_ext[FrameIdxW-1:0];
      res_ev_vld_q  <= do_evict;
      res_ev_page_q <= do_evict ? ev_ext[PageNumW-1:0] : '0;
      res_fault_q   <= fault_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OutDataW - OutFieldW)'(0), res_fault_q, res_ev_page_q,
                          res_ev_vld_q, res_fidx_q, res_hit_q};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  logic [FRAMES-1:0] newest_vec;

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      newest_vec[i] = frame_valid_q[i] && (rank_q[i] == '0);
    end
  end

  // Fill count never passes the built frame count
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CntW'(FRAMES))
    else $error("fill count beyond frame count");

  // Only one valid frame can be the most recent
  a_one_newest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(newest_vec) <= 1)
    else $error("several frames hold the newest rank");

  // An eviction only happens once every active frame is filled
  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && do_evict |-> filled_q >= n_eff)
    else $error("eviction with a free frame left");

  // An empty result register never stalls the input
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready)
    else $error("input stalled with result register empty");

endmodule
